/* hdl/rfre_pkg.sv */
package rfre_pkg;

  localparam int RFRE_MAX_WIDTH  = 256;
  localparam int RFRE_MAX_HEIGHT = 256;

  localparam int CFG_W     = 9;
  localparam int OP_W      = 3;
  localparam int COORD_W   = 16;
  localparam int WRAP_IN_W = COORD_W + 1;
  localparam int COLOR_W   = 8;
  localparam int PIXEL_W   = 3 * COLOR_W;

  localparam logic [CFG_W-1:0] FRAME_SIZE_RESET = CFG_W'(256);

  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
  localparam logic [OP_W-1:0] OP_PLOT    = 3'd1;
  localparam logic [OP_W-1:0] OP_FILL    = 3'd2;
  localparam logic [OP_W-1:0] OP_OUTLINE = 3'd3;
  localparam logic [OP_W-1:0] OP_READ    = 3'd4;

  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]           opcode;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] size_x;
    logic signed [COORD_W-1:0] size_y;
    logic [COLOR_W-1:0]        red;
    logic [COLOR_W-1:0]        green;
    logic [COLOR_W-1:0]        blue;
  } cmd_t;

  typedef struct packed {
    logic [COLOR_W-1:0] read_red;
    logic [COLOR_W-1:0] read_green;
    logic [COLOR_W-1:0] read_blue;
  } res_t;

endpackage

/* hdl/rfre_ram.sv */
module rfre_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/rfre_wrap.sv */
module rfre_wrap
  import rfre_pkg::*;
#(
  parameter int MOD_W = 9,
  parameter int REM_W = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [WRAP_IN_W-1:0] value_i,
  input  logic [MOD_W-1:0]            mod_i,
  output logic                        done_o,
  output logic [REM_W-1:0]            rem_o
);

  localparam logic [1:0] W_IDLE = 2'd0;
  localparam logic [1:0] W_RUN  = 2'd1;
  localparam logic [1:0] W_FIX  = 2'd2;
  localparam int CNT_W = $clog2(WRAP_IN_W);

  logic [1:0]           state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 neg_q, neg_d;
  logic [WRAP_IN_W-1:0] mag_q, mag_d;
  logic [MOD_W-1:0]     rem_q, rem_d;
  logic [MOD_W-1:0]     mod_q, mod_d;
  logic [MOD_W:0]       trial;
  logic [MOD_W:0]       diff;
  logic [MOD_W-1:0]     fix_val;

  assign trial   = {rem_q, mag_q[WRAP_IN_W-1]};
  assign diff    = trial - {1'b0, mod_q};
  assign fix_val = (neg_q && (rem_q != '0)) ? (mod_q - rem_q) : rem_q;
  assign done_o  = (state_q == W_FIX);
  assign rem_o   = fix_val[REM_W-1:0];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    rem_d   = rem_q;
    mod_d   = mod_q;
    if (start_i && (state_q != W_RUN)) begin
      neg_d   = value_i[WRAP_IN_W-1];
      mag_d   = value_i[WRAP_IN_W-1] ? (~value_i + 1'b1) : value_i;
      rem_d   = '0;
      mod_d   = mod_i;
      cnt_d   = CNT_W'(WRAP_IN_W - 1);
      state_d = W_RUN;
    end else begin
      case (state_q)
        W_RUN: begin
          rem_d = (trial >= {1'b0, mod_q}) ? diff[MOD_W-1:0] : trial[MOD_W-1:0];
          mag_d = mag_q << 1;
          if (cnt_q == '0) begin
            state_d = W_FIX;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
        W_FIX: begin
          state_d = W_IDLE;
        end
        default: begin
          state_d = W_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    neg_q <= neg_d;
    mag_q <= mag_d;
    rem_q <= rem_d;
    mod_q <= mod_d;
  end

endmodule

/* hdl/rect_fill_raster_engine.sv */
// Rectangle fill raster engine: 2D drawing commands over an RGB frame store
// of MAX_WIDTH x MAX_HEIGHT pixels kept in one single-port synchronous RAM.
// Input channel (in_valid_i / in_stall_o) takes one command transaction;
// every command returns exactly one result transaction on the output
// channel (out_valid_o / out_stall_i), which holds the pixel color for a
// read and zero for every other command. Commands run one at a time.
// Frame width and height must be written on the cfg port while the block
// idles; the block itself does not enforce this. The time a command takes
// is set by the serial wrap unit (17 steps per coordinate) and by the
// one-pixel-per-cycle write port of the RAM; clear sweeps the whole RAM.
// After reset the same sweep zeroes the RAM with in_stall_o high; cfg
// writes are taken during it. A finished result waits in the output
// register while out_stall_i is high; the next command is accepted
// meanwhile and stops before its own result until the register frees.
module rect_fill_raster_engine
  import rfre_pkg::*;
#(
  parameter int MAX_WIDTH  = RFRE_MAX_WIDTH,
  parameter int MAX_HEIGHT = RFRE_MAX_HEIGHT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  cmd_t             in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output res_t             out_data_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = YW + WW;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WRAP0 = 3'd2;
  localparam logic [2:0] S_WRAP1 = 3'd3;
  localparam logic [2:0] S_SEG   = 3'd4;
  localparam logic [2:0] S_DRAW  = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  localparam logic [1:0] SEG_COL0 = 2'd0;
  localparam logic [1:0] SEG_COL1 = 2'd1;
  localparam logic [1:0] SEG_ROW0 = 2'd2;
  localparam logic [1:0] SEG_ROW1 = 2'd3;

  logic [2:0]       state_q, state_d;
  logic [1:0]       seg_q, seg_d;
  logic [AW-1:0]    clr_cnt_q, clr_cnt_d;
  logic             clr_cmd_q, clr_cmd_d;
  cmd_t             cmd_q, cmd_d;
  logic [XW-1:0]    wx0_q, wx0_d, wx1_q, wx1_d;
  logic [YW-1:0]    wy0_q, wy0_d, wy1_q, wy1_d;
  logic [XW-1:0]    cx_q, cx_d, xs_q, xs_d;
  logic [YW-1:0]    cy_q, cy_d;
  logic [WW-1:0]    ncol_q, ncol_d, col_q, col_d;
  logic [HW-1:0]    nrow_q, nrow_d, row_q, row_d;
  logic [CFG_W-1:0] fw_q, fw_d, fh_q, fh_d;

  logic             p_v_q, p_we_q;
  logic [XW-1:0]    p_x_q;
  logic [YW-1:0]    p_y_q;
  logic             a_v_q, a_we_q;
  logic [AW-1:0]    a_addr_q;

  logic             out_valid_q, out_valid_d;
  res_t             out_data_q, out_data_d;

  logic [WW-1:0]    w_eff, w_last;
  logic [HW-1:0]    h_eff, h_last;
  logic             in_acc, out_take, out_load;
  logic             sx_pos, sy_pos;
  logic [WW-1:0]    nx;
  logic [HW-1:0]    ny;
  logic             seg_en;
  logic [XW-1:0]    seg_xs;
  logic [YW-1:0]    seg_ys;
  logic [WW-1:0]    seg_nc;
  logic [HW-1:0]    seg_nr;
  logic             col_last, row_last;

  logic                        wrap_start;
  logic signed [WRAP_IN_W-1:0] wrap_vx, wrap_vy;
  logic                        wx_done, wy_done;
  logic [XW-1:0]               wx_rem;
  logic [YW-1:0]               wy_rem;

  logic [PW-1:0]      row_base, addr_full;
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [PIXEL_W-1:0] ram_wdata, ram_rdata;

  always_comb begin
    if (fw_q == '0) begin
      w_eff = WW'(1);
    end else if (int'(fw_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_q);
    end
    if (fh_q == '0) begin
      h_eff = HW'(1);
    end else if (int'(fh_q) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(fh_q);
    end
  end

  assign w_last = w_eff - WW'(1);
  assign h_last = h_eff - HW'(1);

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && (state_q == S_IDLE);
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign sx_pos = !cmd_q.size_x[COORD_W-1] && (cmd_q.size_x != '0);
  assign sy_pos = !cmd_q.size_y[COORD_W-1] && (cmd_q.size_y != '0);

  always_comb begin
    if ({1'b0, cmd_q.size_x[COORD_W-2:0]} >= COORD_W'(w_eff)) begin
      nx = w_eff;
    end else begin
      nx = WW'(cmd_q.size_x[COORD_W-2:0]);
    end
    if ({1'b0, cmd_q.size_y[COORD_W-2:0]} >= COORD_W'(h_eff)) begin
      ny = h_eff;
    end else begin
      ny = HW'(cmd_q.size_y[COORD_W-2:0]);
    end
  end

  always_comb begin
    seg_en = 1'b0;
    seg_xs = wx0_q;
    seg_ys = wy0_q;
    seg_nc = WW'(1);
    seg_nr = HW'(1);
    case (cmd_q.opcode)
      OP_PLOT, OP_READ: begin
        seg_en = (seg_q == SEG_COL0);
      end
      OP_FILL: begin
        seg_en = (seg_q == SEG_COL0) && sx_pos && sy_pos;
        seg_nc = nx;
        seg_nr = ny;
      end
      OP_OUTLINE: begin
        case (seg_q)
          SEG_COL0: begin
            seg_en = sy_pos;
            seg_nr = ny;
          end
          SEG_COL1: begin
            seg_en = sy_pos;
            seg_xs = wx1_q;
            seg_nr = ny;
          end
          SEG_ROW0: begin
            seg_en = sx_pos;
            seg_nc = nx;
          end
          SEG_ROW1: begin
            seg_en = sx_pos;
            seg_ys = wy1_q;
            seg_nc = nx;
          end
          default: begin
            seg_en = 1'b0;
          end
        endcase
      end
      default: begin
        seg_en = 1'b0;
      end
    endcase
  end

  assign col_last = (col_q == ncol_q - WW'(1));
  assign row_last = (row_q == nrow_q - HW'(1));

  always_comb begin
    if (state_q == S_IDLE) begin
      wrap_vx = {in_data_i.pos_x[COORD_W-1], in_data_i.pos_x};
      wrap_vy = {in_data_i.pos_y[COORD_W-1], in_data_i.pos_y};
    end else begin
      wrap_vx = {cmd_q.pos_x[COORD_W-1], cmd_q.pos_x}
              + {cmd_q.size_x[COORD_W-1], cmd_q.size_x};
      wrap_vy = {cmd_q.pos_y[COORD_W-1], cmd_q.pos_y}
              + {cmd_q.size_y[COORD_W-1], cmd_q.size_y};
    end
  end

  always_comb begin
    state_d     = state_q;
    seg_d       = seg_q;
    clr_cnt_d   = clr_cnt_q;
    clr_cmd_d   = clr_cmd_q;
    cmd_d       = cmd_q;
    wx0_d       = wx0_q;
    wx1_d       = wx1_q;
    wy0_d       = wy0_q;
    wy1_d       = wy1_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    xs_d        = xs_q;
    ncol_d      = ncol_q;
    nrow_d      = nrow_q;
    col_d       = col_q;
    row_d       = row_q;
    wrap_start  = 1'b0;
    case (state_q)
      S_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == AW'(DEPTH - 1)) begin
          clr_cnt_d = '0;
          state_d   = clr_cmd_q ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          cmd_d = in_data_i;
          seg_d = SEG_COL0;
          case (in_data_i.opcode)
            OP_CLEAR: begin
              clr_cmd_d = 1'b1;
              clr_cnt_d = '0;
              state_d   = S_CLEAR;
            end
            OP_PLOT, OP_FILL, OP_OUTLINE, OP_READ: begin
              wrap_start = 1'b1;
              state_d    = S_WRAP0;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_WRAP0: begin
        if (wx_done && wy_done) begin
          wx0_d = wx_rem;
          wy0_d = wy_rem;
          if (cmd_q.opcode == OP_OUTLINE) begin
            wrap_start = 1'b1;
            state_d    = S_WRAP1;
          end else begin
            state_d = S_SEG;
          end
        end
      end
      S_WRAP1: begin
        if (wx_done && wy_done) begin
          wx1_d   = wx_rem;
          wy1_d   = wy_rem;
          state_d = S_SEG;
        end
      end
      S_SEG: begin
        if (seg_en) begin
          cx_d    = seg_xs;
          xs_d    = seg_xs;
          cy_d    = seg_ys;
          ncol_d  = seg_nc;
          nrow_d  = seg_nr;
          col_d   = '0;
          row_d   = '0;
          state_d = S_DRAW;
        end else if (seg_q == SEG_ROW1) begin
          state_d = S_DRAIN;
        end else begin
          seg_d = seg_q + 1'b1;
        end
      end
      S_DRAW: begin
        if (col_last) begin
          col_d = '0;
          cx_d  = xs_q;
          if (row_last) begin
            if (seg_q == SEG_ROW1) begin
              state_d = S_DRAIN;
            end else begin
              seg_d   = seg_q + 1'b1;
              state_d = S_SEG;
            end
          end else begin
            row_d = row_q + 1'b1;
            cy_d  = (cy_q == h_last[YW-1:0]) ? '0 : cy_q + 1'b1;
          end
        end else begin
          col_d = col_q + 1'b1;
          cx_d  = (cx_q == w_last[XW-1:0]) ? '0 : cx_q + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!p_v_q && !a_v_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    fw_d = fw_q;
    fh_d = fh_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:  fw_d = cfg_data_i;
        CFG_FRAME_HEIGHT: fh_d = cfg_data_i;
        default: begin
          fw_d = fw_q;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_take) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      if (cmd_q.opcode == OP_READ) begin
        out_data_d.read_red   = ram_rdata[3*COLOR_W-1:2*COLOR_W];
        out_data_d.read_green = ram_rdata[2*COLOR_W-1:COLOR_W];
        out_data_d.read_blue  = ram_rdata[COLOR_W-1:0];
      end else begin
        out_data_d = '0;
      end
    end
  end

  assign row_base  = PW'(p_y_q) * PW'(w_eff);
  assign addr_full = row_base + PW'(p_x_q);

  always_comb begin
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_addr  = clr_cnt_q;
      ram_wdata = '0;
    end else begin
      ram_we    = a_v_q && a_we_q;
      ram_addr  = a_addr_q;
      ram_wdata = {cmd_q.red, cmd_q.green, cmd_q.blue};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      seg_q       <= SEG_COL0;
      clr_cnt_q   <= '0;
      clr_cmd_q   <= 1'b0;
      p_v_q       <= 1'b0;
      a_v_q       <= 1'b0;
      out_valid_q <= 1'b0;
      fw_q        <= FRAME_SIZE_RESET;
      fh_q        <= FRAME_SIZE_RESET;
    end else begin
      state_q     <= state_d;
      seg_q       <= seg_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_cmd_q   <= clr_cmd_d;
      p_v_q       <= (state_q == S_DRAW);
      a_v_q       <= p_v_q;
      out_valid_q <= out_valid_d;
      fw_q        <= fw_d;
      fh_q        <= fh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    wx0_q      <= wx0_d;
    wx1_q      <= wx1_d;
    wy0_q      <= wy0_d;
    wy1_q      <= wy1_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    xs_q       <= xs_d;
    ncol_q     <= ncol_d;
    nrow_q     <= nrow_d;
    col_q      <= col_d;
    row_q      <= row_d;
    p_x_q      <= cx_q;
    p_y_q      <= cy_q;
    p_we_q     <= (cmd_q.opcode != OP_READ);
    a_we_q     <= p_we_q;
    a_addr_q   <= addr_full[AW-1:0];
    out_data_q <= out_data_d;
  end

  rfre_wrap #(
    .MOD_W (WW),
    .REM_W (XW)
  ) u_wrap_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (wrap_start),
    .value_i (wrap_vx),
    .mod_i   (w_eff),
    .done_o  (wx_done),
    .rem_o   (wx_rem)
  );

  rfre_wrap #(
    .MOD_W (HW),
    .REM_W (YW)
  ) u_wrap_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (wrap_start),
    .value_i (wrap_vy),
    .mod_i   (h_eff),
    .done_o  (wy_done),
    .rem_o   (wy_rem)
  );

  rfre_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule
